FILE: sv/mxbh_pkg.sv
`default_nettype none

package mxbh_pkg;

  // Mix constants, all arithmetic is mod 2^32.
  localparam logic [31:0] HashXorKey = 32'hA3C59AC3;
  localparam logic [31:0] HashMult   = 32'h9E3779B9;
  localparam int unsigned HashShift  = 16;

  // Index of the multiply step inside one mix round (three steps).
  localparam int unsigned StepW    = 2;
  localparam logic [StepW-1:0] StepFirst = 2'd0;
  localparam logic [StepW-1:0] StepLast  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MIX,
    S_OUT
  } mxbh_state_e;

  // Command from the sequencer to the shared multiply unit.
  typedef struct packed {
    logic        clear;  // return the hash state to zero
    logic        first;  // xor data and key into the state, then multiply
    logic        run;    // xor-shift the state, then multiply
    logic [31:0] data;   // word mixed in on a first step
  } mxbh_cmd_t;

endpackage

`default_nettype wire

FILE: sv/mxbh_byte_if.sv
`default_nettype none

interface mxbh_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

FILE: sv/mxbh_hash_if.sv
`default_nettype none

interface mxbh_hash_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

`default_nettype wire

FILE: sv/mxbh_mix.sv
`default_nettype none

// Shared multiply unit: holds the hash state and applies one multiply step per command.
module mxbh_mix (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire mxbh_pkg::mxbh_cmd_t  cmd_i,
  output logic [31:0]               state_o
);

  logic [31:0] state_q;
  logic [31:0] state_d;
  logic [31:0] opnd;
  logic [31:0] prod;

  always_comb begin
    if (cmd_i.first) begin
      opnd = state_q ^ cmd_i.data ^ mxbh_pkg::HashXorKey;
    end else begin
      opnd = state_q ^ (state_q >> mxbh_pkg::HashShift);
    end
  end

  assign prod = opnd * mxbh_pkg::HashMult;

  always_comb begin
    state_d = state_q;
    if (cmd_i.clear) begin
      state_d = '0;
    end else if (cmd_i.first || cmd_i.run) begin
      state_d = prod;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

`default_nettype wire

FILE: sv/multiply_xorshift_byte_hash.sv
`default_nettype none

// Byte-stream hash with a golden-ratio multiply and xor-shift mix. A packet
// comes in one byte per request on byte_i; the request whose last_byte is set
// closes the packet, and one 32-bit hash_value request then leaves on hash_o.
// Bytes are packed into a 32-bit word; the first byte of the packet and every
// fourth byte after it fold the word into the hash state with one mix round,
// and the last byte folds in whatever is left. A mix round is three multiply
// steps on a single shared 32x32 multiplier, one step per cycle. A byte that
// only packs into the word starts no round. A byte that starts a word is
// accepted and then runs the three multiply steps. The last byte runs its
// round and then the output load; when it also starts a word, two rounds
// run back to back before the load. The block accepts no byte while a round
// runs. The result sits in an output register, so the next packet may start
// while the hash is still waiting to be taken; only the output load of a
// following packet waits for that register to empty. After each hash the
// mix and packing state returns to its reset value.
module multiply_xorshift_byte_hash (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mxbh_byte_if.sink   byte_i,
  mxbh_hash_if.source hash_o
);

  mxbh_pkg::mxbh_state_e           state_q, state_d;
  logic [mxbh_pkg::StepW-1:0]      step_q, step_d;
  logic [1:0]                      phase_q, phase_d;
  logic [31:0]                     pend_q, pend_d;
  logic                            last_q, last_d;
  logic                            second_q, second_d;
  logic                            out_valid_q, out_valid_d;
  logic [31:0]                     hash_q, hash_d;
  logic [31:0]                     pend_new;
  logic                            accept;
  logic                            out_free;
  mxbh_pkg::mxbh_cmd_t             cmd;
  logic [31:0]                     mix_state;

  assign byte_i.ready = (state_q == mxbh_pkg::S_IDLE);
  assign accept       = byte_i.valid && byte_i.ready;
  assign pend_new     = {pend_q[23:0], byte_i.data_byte};
  assign out_free     = !out_valid_q || hash_o.ready;

  // Sequencer: decides which multiply step runs and when the hash is loaded.
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    phase_d     = phase_q;
    pend_d      = pend_q;
    last_d      = last_q;
    second_d    = second_q;
    hash_d      = hash_q;
    out_valid_d = out_valid_q;
    cmd         = '0;
    cmd.data    = pend_q;

    if (out_valid_q && hash_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      mxbh_pkg::S_IDLE: begin
        if (accept) begin
          pend_d  = pend_new;
          phase_d = byte_i.last_byte ? 2'd0 : phase_q + 2'd1;
          if ((phase_q == 2'd0) || byte_i.last_byte) begin
            // A word boundary or the end of the packet starts a mix round.
            state_d  = mxbh_pkg::S_MIX;
            step_d   = mxbh_pkg::StepFirst;
            last_d   = byte_i.last_byte;
            second_d = (phase_q == 2'd0) && byte_i.last_byte;
          end
        end
      end
      mxbh_pkg::S_MIX: begin
        cmd.first = (step_q == mxbh_pkg::StepFirst);
        cmd.run   = (step_q != mxbh_pkg::StepFirst);
        step_d    = step_q + 2'd1;
        if (step_q == mxbh_pkg::StepLast) begin
          pend_d = '0;
          step_d = mxbh_pkg::StepFirst;
          if (second_q) begin
            // The last byte also opened a word: mix the empty word once more.
            second_d = 1'b0;
          end else if (last_q) begin
            state_d = mxbh_pkg::S_OUT;
          end else begin
            state_d = mxbh_pkg::S_IDLE;
          end
        end
      end
      mxbh_pkg::S_OUT: begin
        if (out_free) begin
          hash_d      = mix_state;
          out_valid_d = 1'b1;
          cmd.clear   = 1'b1;
          last_d      = 1'b0;
          state_d     = mxbh_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mxbh_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mxbh_pkg::S_IDLE;
      step_q      <= mxbh_pkg::StepFirst;
      phase_q     <= 2'd0;
      pend_q      <= '0;
      last_q      <= 1'b0;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      phase_q     <= phase_d;
      pend_q      <= pend_d;
      last_q      <= last_d;
      second_q    <= second_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q <= hash_d;
  end

  mxbh_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .state_o (mix_state)
  );

  assign hash_o.valid      = out_valid_q;
  assign hash_o.hash_value = hash_q;

  // A byte that neither opens a word nor ends the packet starts no round.
  a_pack_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !byte_i.last_byte && (phase_q != 2'd0)) |=> (state_q == mxbh_pkg::S_IDLE))
    else $error("packing byte started a mix round");

  // A new hash appears only out of the output load state.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == mxbh_pkg::S_OUT))
    else $error("hash presented without a finished packet");

  // When the hash is loaded, the packing word and position are already clear.
  a_out_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mxbh_pkg::S_OUT) |-> ((phase_q == 2'd0) && (pend_q == '0) && !second_q))
    else $error("state not cleared before hash load");

  // The last byte always starts a mix round from its first step.
  a_last_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && byte_i.last_byte) |=>
      ((state_q == mxbh_pkg::S_MIX) && (step_q == mxbh_pkg::StepFirst) && last_q))
    else $error("last byte did not start the final mix");

endmodule

`default_nettype wire
